// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL, clocked on clk_i with reset held off.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/fcsg_pkg.sv -----
package fcsg_pkg;

  // Grid geometry and request limits
  localparam int CELL_PIXELS  = 20;
  localparam int GRID_CELLS   = 64;
  localparam int MAX_DIAMETER = 127;

  // Field and datapath widths
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int DIA_W    = 7;
  localparam int CODE_W   = 3;
  localparam int COORD_W  = 12;
  localparam int OFFX_W   = 8;
  localparam int OFFY_W   = 7;
  localparam int ERR_W    = 16;
  localparam int CHAN_W   = 8;
  localparam int RGB_W    = 3 * CHAN_W;

  // Colour codes
  localparam logic [CODE_W-1:0] COLOR_WHITE   = 3'd0;
  localparam logic [CODE_W-1:0] COLOR_RED     = 3'd1;
  localparam logic [CODE_W-1:0] COLOR_GREEN   = 3'd2;
  localparam logic [CODE_W-1:0] COLOR_YELLOW  = 3'd3;
  localparam logic [CODE_W-1:0] COLOR_BLUE    = 3'd4;
  localparam logic [CODE_W-1:0] COLOR_MAGENTA = 3'd5;
  localparam logic [CODE_W-1:0] COLOR_CYAN    = 3'd6;

  localparam logic [RGB_W-1:0] RGB_WHITE   = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] RGB_RED     = 24'hFF0000;
  localparam logic [RGB_W-1:0] RGB_GREEN   = 24'h00FF00;
  localparam logic [RGB_W-1:0] RGB_YELLOW  = 24'hFFFF00;
  localparam logic [RGB_W-1:0] RGB_BLUE    = 24'h0000FF;
  localparam logic [RGB_W-1:0] RGB_MAGENTA = 24'hFF00FF;
  localparam logic [RGB_W-1:0] RGB_CYAN    = 24'h00FFFF;

  // Colour code to RGB, unknown codes draw white
  function automatic logic [RGB_W-1:0] pick_colour(input logic [CODE_W-1:0] code);
    logic [RGB_W-1:0] rgb;
    unique case (code)
      COLOR_RED:     rgb = RGB_RED;
      COLOR_GREEN:   rgb = RGB_GREEN;
      COLOR_YELLOW:  rgb = RGB_YELLOW;
      COLOR_BLUE:    rgb = RGB_BLUE;
      COLOR_MAGENTA: rgb = RGB_MAGENTA;
      COLOR_CYAN:    rgb = RGB_CYAN;
      default:       rgb = RGB_WHITE;
    endcase
    return rgb;
  endfunction

  // Pixel centre of a grid cell, cell saturated to the grid
  function automatic logic [COORD_W-1:0] cell_centre(input logic [ROW_W-1:0] cell_idx);
    logic [ROW_W-1:0] cell_sat;
    cell_sat = ((ROW_W+1)'(cell_idx) >= (ROW_W+1)'(GRID_CELLS)) ?
               ROW_W'(GRID_CELLS - 1) : cell_idx;
    return COORD_W'(int'(cell_sat) * CELL_PIXELS + CELL_PIXELS / 2);
  endfunction

  // Radius from diameter, diameter saturated to the limit
  function automatic logic [OFFX_W-1:0] radius_of(input logic [DIA_W-1:0] dia);
    logic [DIA_W-1:0] dia_sat;
    dia_sat = ((DIA_W+1)'(dia) > (DIA_W+1)'(MAX_DIAMETER)) ?
              DIA_W'(MAX_DIAMETER) : dia;
    return OFFX_W'(dia_sat >> 1);
  endfunction

endpackage

// ----- sv/filled_circle_span_generator_top.sv -----
// Filled circle span generator. Each accepted item (grid cell, diameter, colour
// code) starts a midpoint circle walk; every step of the walk yields one result
// item holding two mirrored pairs of horizontal spans (rows cy+-y over cx-x..cx+x
// and rows cy+-x over cx-y..cx+y), the draw colour and a last flag on the final
// step. A single 16-bit adder carries the error-term update and the step test,
// so each result passes the span, compare and x-step states of a small sequencer,
// plus stalls while the output register is still held. A circle of radius r
// gives about 0.71*r+1 results (46 at the largest radius of 63). The block
// accepts no new item until the last result of the current circle is loaded into
// the output register; that result may still wait there while the next item enters.
`include "assert_macros.svh"

module filled_circle_span_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fcsg_pkg::ROW_W-1:0]        grid_row_i,
  input  logic [fcsg_pkg::COL_W-1:0]        grid_col_i,
  input  logic [fcsg_pkg::DIA_W-1:0]        diameter_i,
  input  logic [fcsg_pkg::CODE_W-1:0]       color_code_i,
  // span channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fcsg_pkg::COORD_W-1:0] row_a_below_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] row_a_above_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] left_a_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] right_a_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] row_b_below_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] row_b_above_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] left_b_o,
  output logic signed [fcsg_pkg::COORD_W-1:0] right_b_o,
  output logic [fcsg_pkg::CHAN_W-1:0]       red_o,
  output logic [fcsg_pkg::CHAN_W-1:0]       green_o,
  output logic [fcsg_pkg::CHAN_W-1:0]       blue_o,
  output logic                              last_o
);

  localparam int COORD_W = fcsg_pkg::COORD_W;
  localparam int OFFX_W  = fcsg_pkg::OFFX_W;
  localparam int OFFY_W  = fcsg_pkg::OFFY_W;
  localparam int ERR_W   = fcsg_pkg::ERR_W;
  localparam int CHAN_W  = fcsg_pkg::CHAN_W;
  localparam int RGB_W   = fcsg_pkg::RGB_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SPAN  = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_STEPX = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [COORD_W-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic [RGB_W-1:0]          rgb_q, rgb_d;
  logic signed [OFFX_W-1:0]  x_q, x_d;
  logic [OFFY_W-1:0]         y_q, y_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic                      dec_q, dec_d;

  logic                      out_valid_q, out_valid_d;
  logic                      last_q, last_d;
  logic [COORD_W-1:0]        ra_bel_q, ra_bel_d, ra_abv_q, ra_abv_d;
  logic [COORD_W-1:0]        la_q, la_d, rta_q, rta_d;
  logic [COORD_W-1:0]        rb_bel_q, rb_bel_d, rb_abv_q, rb_abv_d;
  logic [COORD_W-1:0]        lb_q, lb_d, rtb_q, rtb_d;
  logic [RGB_W-1:0]          out_rgb_q, out_rgb_d;

  logic                      in_fire;
  logic                      out_free;
  logic [OFFY_W-1:0]         y_inc;
  logic signed [ERR_W-1:0]   x_ext;
  logic signed [ERR_W-1:0]   add_b;
  logic signed [ERR_W-1:0]   add_sum;
  logic signed [OFFX_W-1:0]  x_next;
  logic [COORD_W-1:0]        x12, y12;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign y_inc  = y_q + OFFY_W'(1);
  assign x_ext  = {{(ERR_W-OFFX_W){x_q[OFFX_W-1]}}, x_q};
  assign x12    = {{(COORD_W-OFFX_W){x_q[OFFX_W-1]}}, x_q};
  assign y12    = {{(COORD_W-OFFY_W){1'b0}}, y_q};
  assign x_next = dec_q ? (x_q - OFFX_W'(1)) : x_q;

  // Shared adder: error update on y step, step test, error update on x step
  always_comb begin
    unique case (state_q)
      S_SPAN:  add_b = ERR_W'({y_inc, 1'b1});
      S_CMP:   add_b = -x_ext;
      S_STEPX: add_b = ERR_W'(3) - (x_ext <<< 1);
      default: add_b = '0;
    endcase
  end
  assign add_sum = err_q + add_b;

  // Sequencer and walk state
  always_comb begin
    state_d     = state_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    rgb_d       = rgb_q;
    x_d         = x_q;
    y_d         = y_q;
    err_d       = err_q;
    dec_d       = dec_q;
    last_d      = last_q;
    ra_bel_d    = ra_bel_q;
    ra_abv_d    = ra_abv_q;
    la_d        = la_q;
    rta_d       = rta_q;
    rb_bel_d    = rb_bel_q;
    rb_abv_d    = rb_abv_q;
    lb_d        = lb_q;
    rtb_d       = rtb_q;
    out_rgb_d   = out_rgb_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cx_d    = fcsg_pkg::cell_centre(grid_col_i);
          cy_d    = fcsg_pkg::cell_centre(grid_row_i);
          rgb_d   = fcsg_pkg::pick_colour(color_code_i);
          x_d     = fcsg_pkg::radius_of(diameter_i);
          y_d     = '0;
          err_d   = '0;
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        // load spans for the current offsets, then advance y
        if (out_free) begin
          ra_bel_d  = cy_q + y12;
          ra_abv_d  = cy_q - y12;
          la_d      = cx_q - x12;
          rta_d     = cx_q + x12;
          rb_bel_d  = cy_q + x12;
          rb_abv_d  = cy_q - x12;
          lb_d      = cx_q - y12;
          rtb_d     = cx_q + y12;
          out_rgb_d = rgb_q;
          y_d       = y_inc;
          err_d     = add_sum;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        // step x when err >= x
        dec_d   = !add_sum[ERR_W-1];
        state_d = S_STEPX;
      end
      default: begin
        if (dec_q) begin
          x_d   = x_next;
          err_d = add_sum;
        end
        last_d      = !($signed(x_next) >= $signed({1'b0, y_q}));
        out_valid_d = 1'b1;
        state_d     = ($signed(x_next) >= $signed({1'b0, y_q})) ? S_SPAN : S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      err_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      rgb_q       <= fcsg_pkg::RGB_WHITE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      y_q         <= y_d;
      err_q       <= err_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      rgb_q       <= rgb_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dec_q     <= dec_d;
    last_q    <= last_d;
    ra_bel_q  <= ra_bel_d;
    ra_abv_q  <= ra_abv_d;
    la_q      <= la_d;
    rta_q     <= rta_d;
    rb_bel_q  <= rb_bel_d;
    rb_abv_q  <= rb_abv_d;
    lb_q      <= lb_d;
    rtb_q     <= rtb_d;
    out_rgb_q <= out_rgb_d;
  end

  assign out_valid_o   = out_valid_q;
  assign last_o        = last_q;
  assign row_a_below_o = ra_bel_q;
  assign row_a_above_o = ra_abv_q;
  assign left_a_o      = la_q;
  assign right_a_o     = rta_q;
  assign row_b_below_o = rb_bel_q;
  assign row_b_above_o = rb_abv_q;
  assign left_b_o      = lb_q;
  assign right_b_o     = rtb_q;
  assign red_o         = out_rgb_q[RGB_W-1 -: CHAN_W];
  assign green_o       = out_rgb_q[CHAN_W +: CHAN_W];
  assign blue_o        = out_rgb_q[CHAN_W-1:0];

  // A non-final span item implies the walk is still running
  `ASSERT_NEVER(a_walk_alive, out_valid_o && !last_o && (state_q == S_IDLE), "walk ended before last item")
  // Each loaded span advances y by exactly one
  `ASSERT_CLK(a_y_step, (state_q == S_SPAN) && out_free |=> (y_q == $past(y_q) + OFFY_W'(1)), "y did not step")
  // Pair A span is never reversed
  `ASSERT_CLK(a_span_order, out_valid_o |-> ($signed(left_a_o) <= $signed(right_a_o)), "span A reversed")

endmodule
